[design/touch_gesture_event_mapper_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the touch gesture event mapper checks
// Shared property forms, all clocked on i_clk and disabled while in reset.
// ---------------------------------------------------------------------------
`ifndef TOUCH_GESTURE_EVENT_MAPPER_DEFINES_SVH
`define TOUCH_GESTURE_EVENT_MAPPER_DEFINES_SVH

// same-cycle implication
`define TGEM_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tgem check failed: same-cycle rule");

// next-cycle implication
`define TGEM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tgem check failed: next-cycle rule");

`endif

[design/tgem_pkg.sv]
// ---------------------------------------------------------------------------
// tgem_pkg
// Types, codes and constants shared by the touch gesture event mapper.
// ---------------------------------------------------------------------------
package tgem_pkg;

    localparam int COORD_W   = 16;
    localparam int TIME_W    = 32;
    localparam int PROD_W    = 2 * COORD_W;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 16;

    // status byte decode
    localparam int          STATUS_READY_BIT = 7;
    localparam logic [3:0]  MAX_CONTACTS     = 4'd5;

    // long press re-arm offset
    localparam logic [TIME_W-1:0] LONG_EXTEND_MS = 32'd10000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOUCH_W  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOUCH_H  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DISP_W   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DISP_H   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_X = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_Y = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_MS  = 4'd7;

    // register reset values
    localparam logic [COORD_W-1:0] RST_TOUCH_W = 16'd800;
    localparam logic [COORD_W-1:0] RST_TOUCH_H = 16'd480;
    localparam logic [COORD_W-1:0] RST_DISP_W  = 16'd800;
    localparam logic [COORD_W-1:0] RST_DISP_H  = 16'd480;
    localparam logic [COORD_W-1:0] RST_LONG_MS = 16'd2000;

    // effective quarter turns
    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    typedef enum logic [2:0] {
        EV_PRESSED       = 3'd0,
        EV_MOVED         = 3'd1,
        EV_LONG_PRESSED  = 3'd2,
        EV_RELEASED      = 3'd3,
        EV_LONG_RELEASED = 3'd4
    } t_event;

    typedef enum logic [1:0] {
        CNT_NONE  = 2'd0,
        CNT_ONE   = 2'd1,
        CNT_MULTI = 2'd2
    } t_contacts;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic map;
        logic mul;
        logic div_start;
        logic commit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic one_contact;
        logic div_busy;
        logic emit;
    } t_stat;

endpackage

[design/tgem_divider.sv]
// ---------------------------------------------------------------------------
// tgem_divider
// Restoring divider, one quotient bit per cycle, 32-bit dividend by 16-bit
// divisor. Only the low 16 quotient bits are presented.
// ---------------------------------------------------------------------------
module tgem_divider (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [tgem_pkg::PROD_W-1:0]  i_dividend,
    input  logic [tgem_pkg::COORD_W-1:0] i_divisor,
    output logic                         o_busy,
    output logic [tgem_pkg::COORD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(tgem_pkg::PROD_W);

    logic                         r_busy;
    logic [CNT_W-1:0]             r_cnt;
    logic [tgem_pkg::COORD_W-1:0] r_rem;
    logic [tgem_pkg::COORD_W-1:0] r_den;
    logic [tgem_pkg::PROD_W-1:0]  r_quo;

    logic [tgem_pkg::COORD_W:0]   trial;
    logic [tgem_pkg::COORD_W:0]   diff;
    logic                         ge;
    logic [tgem_pkg::COORD_W-1:0] n_rem;

    // one trial subtraction per cycle
    always_comb begin
        trial = {r_rem, r_quo[tgem_pkg::PROD_W-1]};
        diff  = trial - {1'b0, r_den};
        ge    = (trial >= {1'b0, r_den});
        n_rem = ge ? diff[tgem_pkg::COORD_W-1:0] : trial[tgem_pkg::COORD_W-1:0];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(tgem_pkg::PROD_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // datapath: dividend shifts out on top, quotient bits enter at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[tgem_pkg::PROD_W-2:0], ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo[tgem_pkg::COORD_W-1:0];

endmodule

[design/tgem_datapath.sv]
// ---------------------------------------------------------------------------
// tgem_datapath
// Configuration registers, point transform, scaling and gesture state.
// ---------------------------------------------------------------------------
module tgem_datapath #(
    parameter logic [3:0] MAX_CONTACTS = tgem_pkg::MAX_CONTACTS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [tgem_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tgem_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    // poll item
    input  logic [7:0]                      i_status_byte,
    input  logic [tgem_pkg::COORD_W-1:0]    i_raw_x,
    input  logic [tgem_pkg::COORD_W-1:0]    i_raw_y,
    input  logic [tgem_pkg::TIME_W-1:0]     i_now_ms,
    // control
    input  tgem_pkg::t_cmd                  i_cmd,
    output tgem_pkg::t_stat                 o_stat,
    // result payload
    output logic [2:0]                      o_event_kind,
    output logic [tgem_pkg::COORD_W-1:0]    o_point_x,
    output logic [tgem_pkg::COORD_W-1:0]    o_point_y
);

    localparam int CW = tgem_pkg::COORD_W;
    localparam int TW = tgem_pkg::TIME_W;

    // configuration registers
    logic [CW-1:0] r_touch_w, r_touch_h, r_disp_w, r_disp_h, r_long_ms;
    logic [1:0]    r_rot;
    logic          r_mir_x, r_mir_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_touch_w <= tgem_pkg::RST_TOUCH_W;
            r_touch_h <= tgem_pkg::RST_TOUCH_H;
            r_disp_w  <= tgem_pkg::RST_DISP_W;
            r_disp_h  <= tgem_pkg::RST_DISP_H;
            r_rot     <= 2'd0;
            r_mir_x   <= 1'b0;
            r_mir_y   <= 1'b0;
            r_long_ms <= tgem_pkg::RST_LONG_MS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tgem_pkg::CFG_TOUCH_W:  r_touch_w <= i_cfg_data;
                tgem_pkg::CFG_TOUCH_H:  r_touch_h <= i_cfg_data;
                tgem_pkg::CFG_DISP_W:   r_disp_w  <= i_cfg_data;
                tgem_pkg::CFG_DISP_H:   r_disp_h  <= i_cfg_data;
                tgem_pkg::CFG_ROTATION: r_rot     <= i_cfg_data[1:0];
                tgem_pkg::CFG_MIRROR_X: r_mir_x   <= i_cfg_data[0];
                tgem_pkg::CFG_MIRROR_Y: r_mir_y   <= i_cfg_data[0];
                tgem_pkg::CFG_LONG_MS:  r_long_ms <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input capture and contact classification
    logic [CW-1:0]        r_raw_x, r_raw_y;
    logic [TW-1:0]        r_now;
    tgem_pkg::t_contacts  r_cls;
    tgem_pkg::t_contacts  in_cls;
    logic [3:0]           in_cnt;

    always_comb begin
        in_cnt = i_status_byte[3:0];
        if (!i_status_byte[tgem_pkg::STATUS_READY_BIT] || (in_cnt >= MAX_CONTACTS)
            || (in_cnt == 4'd0)) begin
            in_cls = tgem_pkg::CNT_NONE;
        end else if (in_cnt == 4'd1) begin
            in_cls = tgem_pkg::CNT_ONE;
        end else begin
            in_cls = tgem_pkg::CNT_MULTI;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_raw_x <= i_raw_x;
            r_raw_y <= i_raw_y;
            r_now   <= i_now_ms;
            r_cls   <= in_cls;
        end
    end

    // mirror and rotate
    logic [CW-1:0] tw1, th1, mx, my, xr, yr, den_x, den_y;
    logic [1:0]    quarter;

    always_comb begin
        tw1     = r_touch_w - 1'b1;
        th1     = r_touch_h - 1'b1;
        mx      = r_mir_x ? (tw1 - r_raw_x) : r_raw_x;
        my      = r_mir_y ? (th1 - r_raw_y) : r_raw_y;
        quarter = r_rot + 1'b1;
        case (quarter)
            tgem_pkg::ROT_90: begin
                xr = my;          yr = tw1 - mx;
                den_x = th1;      den_y = tw1;
            end
            tgem_pkg::ROT_180: begin
                xr = tw1 - mx;    yr = th1 - my;
                den_x = tw1;      den_y = th1;
            end
            tgem_pkg::ROT_270: begin
                xr = th1 - my;    yr = mx;
                den_x = th1;      den_y = tw1;
            end
            default: begin
                xr = mx;          yr = my;
                den_x = tw1;      den_y = th1;
            end
        endcase
    end

    logic [CW-1:0] r_xr, r_yr, r_num_x, r_num_y, r_den_x, r_den_y;
    logic          r_zero_x, r_zero_y;

    always_ff @(posedge i_clk) begin
        if (i_cmd.map) begin
            r_xr     <= xr;
            r_yr     <= yr;
            r_num_x  <= r_disp_w - 1'b1;
            r_num_y  <= r_disp_h - 1'b1;
            r_den_x  <= den_x;
            r_den_y  <= den_y;
            r_zero_x <= (den_x == '0);
            r_zero_y <= (den_y == '0);
        end
    end

    // scaling products
    logic [tgem_pkg::PROD_W-1:0] r_prod_x, r_prod_y;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod_x <= r_xr * r_num_x;
            r_prod_y <= r_yr * r_num_y;
        end
    end

    // one divider per axis, running side by side
    logic          busy_x, busy_y;
    logic [CW-1:0] quo_x, quo_y;

    tgem_divider u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_prod_x),
        .i_divisor  (r_den_x),
        .o_busy     (busy_x),
        .o_quotient (quo_x)
    );

    tgem_divider u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_prod_y),
        .i_divisor  (r_den_y),
        .o_busy     (busy_y),
        .o_quotient (quo_y)
    );

    // gesture state
    logic          r_touch_active, r_long_active;
    logic [CW-1:0] r_last_x, r_last_y;
    logic [TW-1:0] r_press_start;

    logic [CW-1:0]   px, py;
    logic [TW-1:0]   deadline;
    logic            moved, long_due;
    logic            emit;
    tgem_pkg::t_event kind;
    logic            n_touch_active, n_long_active, upd_point, upd_start;
    logic [TW-1:0]   n_press_start;

    // gesture decision
    always_comb begin
        px       = r_zero_x ? {CW{1'b1}} : quo_x;
        py       = r_zero_y ? {CW{1'b1}} : quo_y;
        deadline = r_press_start + {{(TW-CW){1'b0}}, r_long_ms};
        moved    = (px != r_last_x) || (py != r_last_y);
        long_due = !r_long_active && (r_now > deadline);

        emit           = 1'b0;
        kind           = tgem_pkg::EV_PRESSED;
        n_touch_active = r_touch_active;
        n_long_active  = r_long_active;
        upd_point      = 1'b0;
        upd_start      = 1'b0;
        n_press_start  = r_now;

        case (r_cls)
            tgem_pkg::CNT_ONE: begin
                if (!r_touch_active) begin
                    emit           = 1'b1;
                    kind           = tgem_pkg::EV_PRESSED;
                    upd_point      = 1'b1;
                    upd_start      = 1'b1;
                    n_touch_active = 1'b1;
                end else if (moved) begin
                    emit      = 1'b1;
                    kind      = tgem_pkg::EV_MOVED;
                    upd_point = 1'b1;
                end else if (long_due) begin
                    emit          = 1'b1;
                    kind          = tgem_pkg::EV_LONG_PRESSED;
                    n_long_active = 1'b1;
                    upd_start     = 1'b1;
                    n_press_start = r_now + tgem_pkg::LONG_EXTEND_MS;
                end
            end
            tgem_pkg::CNT_NONE: begin
                if (r_touch_active && !r_long_active) begin
                    emit           = 1'b1;
                    kind           = tgem_pkg::EV_RELEASED;
                    n_touch_active = 1'b0;
                end else if (r_long_active) begin
                    emit           = 1'b1;
                    kind           = tgem_pkg::EV_LONG_RELEASED;
                    n_touch_active = 1'b0;
                    n_long_active  = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_touch_active <= 1'b0;
            r_long_active  <= 1'b0;
            r_last_x       <= '0;
            r_last_y       <= '0;
            r_press_start  <= '0;
        end else if (i_cmd.commit) begin
            r_touch_active <= n_touch_active;
            r_long_active  <= n_long_active;
            if (upd_point) begin
                r_last_x <= px;
                r_last_y <= py;
            end
            if (upd_start) begin
                r_press_start <= n_press_start;
            end
        end
    end

    // result register; new points go out with pressed and moved
    tgem_pkg::t_event r_kind;
    logic [CW-1:0]    r_out_x, r_out_y;

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && emit) begin
            r_kind  <= kind;
            r_out_x <= upd_point ? px : r_last_x;
            r_out_y <= upd_point ? py : r_last_y;
        end
    end

    assign o_event_kind = r_kind;
    assign o_point_x    = r_out_x;
    assign o_point_y    = r_out_y;

    assign o_stat.one_contact = (r_cls == tgem_pkg::CNT_ONE);
    assign o_stat.div_busy    = busy_x || busy_y;
    assign o_stat.emit        = emit;

endmodule

[design/tgem_ctrl.sv]
// ---------------------------------------------------------------------------
// tgem_ctrl
// Sequencer for one poll item and owner of the result valid flag.
// ---------------------------------------------------------------------------
module tgem_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  tgem_pkg::t_stat  i_stat,
    output tgem_pkg::t_cmd   o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_MUL,
        ST_START,
        ST_DIV,
        ST_DECIDE
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    // command decode
    always_comb begin
        o_cmd           = '0;
        o_cmd.load_in   = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.map       = (r_state == ST_MAP);
        o_cmd.mul       = (r_state == ST_MUL);
        o_cmd.div_start = (r_state == ST_START);
        o_cmd.commit    = (r_state == ST_DECIDE) && slot_free;
    end

    // state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.commit && i_stat.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) r_state <= ST_MAP;
                end
                ST_MAP: begin
                    r_state <= i_stat.one_contact ? ST_MUL : ST_DECIDE;
                end
                ST_MUL:   r_state <= ST_START;
                ST_START: r_state <= ST_DIV;
                ST_DIV: begin
                    if (!i_stat.div_busy) r_state <= ST_DECIDE;
                end
                ST_DECIDE: begin
                    if (slot_free) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[design/touch_gesture_event_mapper.sv]
// ---------------------------------------------------------------------------
// touch_gesture_event_mapper
// Maps touch controller polls to display-space gesture events.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one poll: status byte, raw
//   first-contact point and a millisecond time. Output channel (o_out_valid /
//   i_out_ready) gives zero or one event per poll with its display point.
//   Config channel (i_cfg_valid / o_cfg_ready) is always ready; write only
//   while no poll is in flight. Unknown register indexes are ignored.
// Timing:
//   A single-contact poll goes from transfer to result through map,
//   multiply, divider load, the bit-serial dividers (one per axis, in
//   parallel), a check that they are done, then the decision. Other polls
//   go from map straight to the decision. One poll is in flight at a time
//   and the next is taken the cycle after the decision.
// Reset and stall:
//   Synchronous reset restores the register defaults and clears the gesture
//   state. A finished event waits in the output register; the next poll is
//   taken meanwhile, and its decision holds until the output register frees.
// ---------------------------------------------------------------------------
module touch_gesture_event_mapper #(
    parameter logic [3:0] MAX_CONTACTS = tgem_pkg::MAX_CONTACTS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // poll channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [7:0]                      i_status_byte,
    input  logic [tgem_pkg::COORD_W-1:0]    i_raw_x,
    input  logic [tgem_pkg::COORD_W-1:0]    i_raw_y,
    input  logic [tgem_pkg::TIME_W-1:0]     i_now_ms,
    // event channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [2:0]                      o_event_kind,
    output logic [tgem_pkg::COORD_W-1:0]    o_point_x,
    output logic [tgem_pkg::COORD_W-1:0]    o_point_y,
    // configuration channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tgem_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tgem_pkg::CFG_DAT_W-1:0]  i_cfg_data
);

    tgem_pkg::t_cmd  cmd;
    tgem_pkg::t_stat stat;

    assign o_cfg_ready = 1'b1;

    tgem_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    tgem_datapath #(
        .MAX_CONTACTS (MAX_CONTACTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_status_byte (i_status_byte),
        .i_raw_x       (i_raw_x),
        .i_raw_y       (i_raw_y),
        .i_now_ms      (i_now_ms),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_event_kind  (o_event_kind),
        .o_point_x     (o_point_x),
        .o_point_y     (o_point_y)
    );

endmodule

[design/tgem_checker.sv]
// ---------------------------------------------------------------------------
// tgem_checker
// Port-level checks for the touch gesture event mapper, bound to the top.
// ---------------------------------------------------------------------------
`include "touch_gesture_event_mapper_defines.svh"

module tgem_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_ready,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input logic [2:0]                      o_event_kind,
    input logic [tgem_pkg::COORD_W-1:0]    o_point_x,
    input logic [tgem_pkg::COORD_W-1:0]    o_point_y,
    input logic                            i_cfg_valid,
    input logic                            o_cfg_ready
);

    // whole event payload
    logic [2*tgem_pkg::COORD_W+2:0] out_word;

    assign out_word = {o_event_kind, o_point_x, o_point_y};

    // a stalled event keeps its payload
    `TGEM_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(out_word))

    // one poll in flight: a transfer closes the input side
    `TGEM_ASSERT_NEXT(a_in_busy, i_in_valid && o_in_ready, !o_in_ready)

    // a new event is only raised while a poll is being decided
    `TGEM_ASSERT_IMPL(a_event_src, $rose(o_out_valid), !$past(o_in_ready))

    // configuration is never back-pressured
    `TGEM_ASSERT_IMPL(a_cfg_ready, i_cfg_valid, o_cfg_ready)

endmodule

bind touch_gesture_event_mapper tgem_checker u_tgem_checker (.*);

[sim/touch_gesture_event_mapper_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// touch_gesture_event_mapper_test
// Drives touch polls into the mapper and checks every gesture event that it
// emits. The bench keeps its own copy of the transform and gesture state,
// predicts one event or none per accepted poll, and compares the event
// stream field by field. Directed cases come first, then random touch
// sessions under sixteen register settings, with bursty input and output
// stalls.
// ---------------------------------------------------------------------------
module touch_gesture_event_mapper_test;
    import tgem_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 60;    // longer than a single-contact poll takes
    localparam int NUM_PHASES    = 16;
    localparam int PHASE_POLLS   = 88;

    typedef struct packed {
        t_event             kind;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } gesture_event_t;

    // DUT ports
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_in_valid    = 1'b0;
    logic                 o_in_ready;
    logic [7:0]           i_status_byte = '0;
    logic [COORD_W-1:0]   i_raw_x       = '0;
    logic [COORD_W-1:0]   i_raw_y       = '0;
    logic [TIME_W-1:0]    i_now_ms      = '0;
    logic                 o_out_valid;
    logic                 i_out_ready   = 1'b0;
    logic [2:0]           o_event_kind;
    logic [COORD_W-1:0]   o_point_x;
    logic [COORD_W-1:0]   o_point_y;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data    = '0;

    // shadow registers
    logic [15:0] cfg_touch_w  = RST_TOUCH_W;
    logic [15:0] cfg_touch_h  = RST_TOUCH_H;
    logic [15:0] cfg_disp_w   = RST_DISP_W;
    logic [15:0] cfg_disp_h   = RST_DISP_H;
    logic [1:0]  cfg_rotation = 2'd0;
    logic        cfg_mirror_x = 1'b0;
    logic        cfg_mirror_y = 1'b0;
    logic [15:0] cfg_long_ms  = RST_LONG_MS;

    // shadow gesture state
    logic        ges_active = 1'b0;
    logic        ges_long   = 1'b0;
    logic [15:0] ges_x      = '0;
    logic [15:0] ges_y      = '0;
    logic [31:0] ges_start  = '0;

    gesture_event_t pending_events[$];
    int             mismatch_count = 0;
    int             poll_count     = 0;
    int             cycle_count    = 0;
    int             burst_left     = 0;
    logic [31:0]    clock_ms       = '0;

    touch_gesture_event_mapper i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_status_byte (i_status_byte),
        .i_raw_x       (i_raw_x),
        .i_raw_y       (i_raw_y),
        .i_now_ms      (i_now_ms),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_event_kind  (o_event_kind),
        .o_point_x     (o_point_x),
        .o_point_y     (o_point_y),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL touch_gesture_event_mapper");
            $finish;
        end
    end

    // event sink stalls: mode rotates with bits 10:9 of the cycle count
    always @(posedge i_clk) begin
        case (cycle_count[10:9])
            2'd0: i_out_ready <= 1'b1;
            2'd1: i_out_ready <= 1'($urandom_range(0, 1));
            2'd2: i_out_ready <= (cycle_count[4:0] == 5'd0);
            default: i_out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // compare each event transfer with the oldest prediction
    always @(posedge i_clk) begin
        gesture_event_t exp_ev;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_events.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected event: kind %0d point (%0d,%0d)",
                             o_event_kind, o_point_x, o_point_y);
            end else begin
                exp_ev = pending_events.pop_front();
                if (o_event_kind != exp_ev.kind || o_point_x != exp_ev.x ||
                    o_point_y != exp_ev.y) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("event mismatch: expected kind %0d (%0d,%0d), got kind %0d (%0d,%0d)",
                                 exp_ev.kind, exp_ev.x, exp_ev.y,
                                 o_event_kind, o_point_x, o_point_y);
                end
            end
        end
    end

    // v * (disp-1) / (touch-1), all-ones on a zero divisor
    function automatic logic [15:0] scale_axis(input logic [15:0] v, disp, touch);
        logic [15:0] num;
        logic [15:0] den;
        logic [31:0] quot;
        num = disp - 16'd1;
        den = touch - 16'd1;
        if (den == 16'd0)
            return 16'hFFFF;
        quot = ({16'd0, v} * {16'd0, num}) / {16'd0, den};
        return quot[15:0];
    endfunction

    // mirror, rotate and scale a raw point into display space
    function automatic void map_point(input logic [15:0] rx, ry,
                                      output logic [15:0] ox, oy);
        logic [15:0] tw, th, mx, my, xr, yr, sw;
        logic [1:0]  turns;
        tw    = cfg_touch_w;
        th    = cfg_touch_h;
        mx    = cfg_mirror_x ? tw - 16'd1 - rx : rx;
        my    = cfg_mirror_y ? th - 16'd1 - ry : ry;
        turns = cfg_rotation + 2'd1;
        xr    = mx;
        yr    = my;
        case (turns)
            ROT_90: begin
                xr = my;
                yr = tw - 16'd1 - mx;
                sw = tw; tw = th; th = sw;
            end
            ROT_180: begin
                xr = tw - 16'd1 - mx;
                yr = th - 16'd1 - my;
            end
            ROT_270: begin
                xr = th - 16'd1 - my;
                yr = mx;
                sw = tw; tw = th; th = sw;
            end
            default: ;
        endcase
        ox = scale_axis(xr, cfg_disp_w, tw);
        oy = scale_axis(yr, cfg_disp_h, th);
    endfunction

    // gesture machine: queue the event this poll causes, if any
    function automatic void predict_gesture(input logic [7:0] status,
                                            input logic [15:0] rx, ry,
                                            input logic [31:0] now);
        t_contacts   contacts;
        logic [15:0] px, py;
        logic [31:0] deadline;
        if (!status[STATUS_READY_BIT] || status[3:0] >= MAX_CONTACTS || status[3:0] == 4'd0)
            contacts = CNT_NONE;
        else if (status[3:0] == 4'd1)
            contacts = CNT_ONE;
        else
            contacts = CNT_MULTI;

        deadline = ges_start + {16'd0, cfg_long_ms};
        if (contacts == CNT_ONE) begin
            map_point(rx, ry, px, py);
            if (!ges_active) begin
                ges_x = px; ges_y = py; ges_start = now; ges_active = 1'b1;
                pending_events.push_back('{EV_PRESSED, px, py});
            end else if (px != ges_x || py != ges_y) begin
                ges_x = px; ges_y = py;
                pending_events.push_back('{EV_MOVED, px, py});
            end else if (!ges_long && now > deadline) begin
                ges_long  = 1'b1;
                ges_start = now + LONG_EXTEND_MS;
                pending_events.push_back('{EV_LONG_PRESSED, ges_x, ges_y});
            end
        end else if (contacts == CNT_NONE) begin
            if (ges_active && !ges_long) begin
                ges_active = 1'b0;
                pending_events.push_back('{EV_RELEASED, ges_x, ges_y});
            end else if (ges_long) begin
                ges_long = 1'b0; ges_active = 1'b0;
                pending_events.push_back('{EV_LONG_RELEASED, ges_x, ges_y});
            end
        end
    endfunction

    // one poll transfer; valid stays high after it unless a gap follows
    task automatic send_poll(input logic [7:0] status, input logic [15:0] rx, ry,
                             input logic [31:0] now);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 3))
                0: gap = 0;
                1: gap = $urandom_range(1, 3);
                2: gap = $urandom_range(4, 12);
                default: gap = $urandom_range(13, 45);
            endcase
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid    <= 1'b1;
        i_status_byte <= status;
        i_raw_x       <= rx;
        i_raw_y       <= ry;
        i_now_ms      <= now;
        do @(posedge i_clk); while (!o_in_ready);
        poll_count++;
        predict_gesture(status, rx, ry, now);
    endtask

    // drop valid, wait for every predicted event, then let the last poll finish
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_TOUCH_W:  cfg_touch_w  = data;
            CFG_TOUCH_H:  cfg_touch_h  = data;
            CFG_DISP_W:   cfg_disp_w   = data;
            CFG_DISP_H:   cfg_disp_h   = data;
            CFG_ROTATION: cfg_rotation = data[1:0];
            CFG_MIRROR_X: cfg_mirror_x = data[0];
            CFG_MIRROR_Y: cfg_mirror_y = data[0];
            CFG_LONG_MS:  cfg_long_ms  = data;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_all_regs(input logic [15:0] tw, th, dw, dh,
                                  input logic [1:0] rot, input logic mxr, myr,
                                  input logic [15:0] long_ms);
        write_reg(CFG_TOUCH_W, tw);
        write_reg(CFG_TOUCH_H, th);
        write_reg(CFG_DISP_W, dw);
        write_reg(CFG_DISP_H, dh);
        write_reg(CFG_ROTATION, {14'd0, rot});
        write_reg(CFG_MIRROR_X, {15'd0, mxr});
        write_reg(CFG_MIRROR_Y, {15'd0, myr});
        write_reg(CFG_LONG_MS, long_ms);
    endtask

    function automatic logic [15:0] pick_size(input logic [15:0] lo);
        case ($urandom_range(0, 9))
            0: return lo;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(lo, 1000));
        endcase
    endfunction

    // mostly inside the sensor range, sometimes anywhere
    function automatic logic [15:0] pick_coord(input logic [15:0] size);
        if ($urandom_range(0, 15) == 0)
            return 16'($urandom());
        return 16'($urandom_range(0, size - 16'd1));
    endfunction

    // step the poll clock; a long step passes the hold time
    function automatic logic [31:0] advance_clock(input bit long_step);
        if (long_step)
            clock_ms += {16'd0, cfg_long_ms} + $urandom_range(1, 5000);
        else
            clock_ms += $urandom_range(0, cfg_long_ms / 3 + 20);
        return clock_ms;
    endfunction

    // status byte with ready set, a given count and junk in bits 6..4
    function automatic logic [7:0] ready_status(input logic [3:0] count);
        return {1'b1, 3'($urandom_range(0, 7)), count};
    endfunction

    // press, hold and release at reset settings, incl. edge timing and wrap
    task automatic test_gesture_basics();
        send_poll(8'h81, 16'd0, 16'd0, 32'd0);                 // pressed
        send_poll(8'h81, 16'd0, 16'd0, 32'd2000);              // exactly at hold time
        send_poll(8'h81, 16'd0, 16'd0, 32'd2001);              // long pressed
        send_poll(8'h81, 16'd0, 16'd0, 32'd30000);             // already long
        send_poll(8'h82, 16'd5, 16'd5, 32'd30001);             // two contacts
        send_poll(8'h80, 16'd0, 16'd0, 32'd30002);             // long released
        send_poll(8'h00, 16'd0, 16'd0, 32'd30003);             // idle, nothing
        send_poll(8'hF1, 16'hFFFF, 16'hFFFF, 32'hFFFF_F000);   // pressed, junk bits
        send_poll(8'h81, 16'd799, 16'd479, 32'hFFFF_FFFF);     // moved
        send_poll(8'h81, 16'd799, 16'd479, 32'h0000_0100);     // time wrapped, not yet
        send_poll(8'h81, 16'd799, 16'd479, 32'hFFFF_FFFF);     // long pressed
        send_poll(8'h85, 16'd0, 16'd0, 32'd100);               // count at max: release
        send_poll(8'h81, 16'd400, 16'd240, 32'd200);           // pressed
        send_poll(8'h84, 16'd1, 16'd1, 32'd300);               // four contacts
        send_poll(8'h01, 16'd400, 16'd240, 32'd400);           // ready low: released
        send_poll(8'h81, 16'd1, 16'd1, 32'd500);               // pressed
        send_poll(8'hFF, 16'd0, 16'd0, 32'd600);               // count 15: released
    endtask

    // zero divisor, unit and full-scale display sizes, zero hold time
    task automatic test_config_extremes();
        wait_idle();
        write_all_regs(16'd1, 16'hFFFF, 16'hFFFF, 16'd1, 2'd3, 1'b1, 1'b1, 16'd0);
        send_poll(8'h81, 16'd0, 16'd0, 32'd5);
        send_poll(8'h81, 16'd0, 16'd0, 32'd6);
        send_poll(8'h80, 16'd0, 16'd0, 32'd7);
        wait_idle();
        write_all_regs(16'd2, 16'd2, 16'hFFFF, 16'hFFFF, 2'd1, 1'b0, 1'b0, 16'hFFFF);
        send_poll(8'h81, 16'd1, 16'd1, 32'd10);
        send_poll(8'h81, 16'hFFFF, 16'd0, 32'd11);
        send_poll(8'h80, 16'd0, 16'd0, 32'd12);
    endtask

    // one touch from press to release with random holds, moves and noise
    task automatic run_session();
        logic [15:0] px, py;
        int          steps;
        if ($urandom_range(0, 7) == 0)
            clock_ms = $urandom();
        px = pick_coord(cfg_touch_w);
        py = pick_coord(cfg_touch_h);
        send_poll(ready_status(4'd1), px, py, advance_clock(1'b0));
        steps = $urandom_range(1, 8);
        repeat (steps) begin
            case ($urandom_range(0, 9))
                5: begin
                    px = pick_coord(cfg_touch_w);
                    py = pick_coord(cfg_touch_h);
                    send_poll(ready_status(4'd1), px, py, advance_clock(1'b0));
                end
                6: begin
                    px = px + 16'($urandom_range(1, 4));
                    send_poll(ready_status(4'd1), px, py, advance_clock(1'b0));
                end
                7: send_poll(ready_status(4'($urandom_range(2, 4))), 16'($urandom()),
                             16'($urandom()), advance_clock(1'b0));
                8: send_poll(8'($urandom()), 16'($urandom()), 16'($urandom()),
                             advance_clock(1'b0));
                9: send_poll(ready_status(4'd1), px, py, advance_clock(1'b1));
                default: send_poll(ready_status(4'd1), px, py, advance_clock(1'b0));
            endcase
        end
        // release by an empty report, a not-ready status or an overflowed count
        case ($urandom_range(0, 2))
            0: send_poll(ready_status(4'd0), 16'($urandom()), 16'($urandom()),
                         advance_clock(1'b0));
            1: send_poll({1'b0, 7'($urandom())}, 16'($urandom()), 16'($urandom()),
                         advance_clock(1'b0));
            default: send_poll(ready_status(4'($urandom_range(MAX_CONTACTS, 15))),
                               16'($urandom()), 16'($urandom()), advance_clock(1'b0));
        endcase
    endtask

    // sixteen settings: every rotation and mirror pairing, sizes at the limits
    task automatic test_random_sessions();
        logic [15:0] tw, th, dw, dh, long_ms;
        int          start_polls;
        for (int p = 0; p < NUM_PHASES; p++) begin
            tw = pick_size(16'd2);
            th = pick_size(16'd2);
            dw = pick_size(16'd1);
            dh = pick_size(16'd1);
            if (p == 0) begin
                tw = 16'hFFFF; th = 16'hFFFF; dw = 16'hFFFF; dh = 16'hFFFF;
            end else if (p == 1) begin
                tw = 16'd2; th = 16'd2; dw = 16'd1; dh = 16'd1;
            end
            case ($urandom_range(0, 5))
                0: long_ms = 16'd0;
                1: long_ms = 16'hFFFF;
                default: long_ms = 16'($urandom_range(0, 3000));
            endcase
            wait_idle();
            write_all_regs(tw, th, dw, dh, 2'(p), p[2], p[3], long_ms);
            start_polls = poll_count;
            while (poll_count - start_polls < PHASE_POLLS)
                run_session();
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_gesture_basics();
        test_config_extremes();
        test_random_sessions();
        wait_idle();
        if (mismatch_count == 0 && pending_events.size() == 0)
            $display("PASS touch_gesture_event_mapper");
        else
            $display("FAIL touch_gesture_event_mapper");
        $finish;
    end

endmodule
